>>> hdl/tfa_pkg.sv
// Shared types, constants and codes for the tile region first-fit allocator.
// Used by every module of the block; depends on nothing.
package tfa_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 32;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int DIM_W       = 6;
    localparam int CFG_IDX_W   = 1;

    localparam logic [DIM_W-1:0] GRID_RESET = 6'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // opcodes
    localparam logic OP_RESERVE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] RSP_DONE    = 2'd0;
    localparam logic [1:0] RSP_NO_ROOM = 2'd1;
    localparam logic [1:0] RSP_BAD     = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [DIM_W-1:0] region_width;
        logic [DIM_W-1:0] region_height;
        logic [4:0]       place_x;
        logic [4:0]       place_y;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] found_x;
        logic [4:0] found_y;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan;
        logic       next_col;
        logic       mark_found;
        logic       release_start;
        logic       write_step;
        logic       set_status;
        logic [1:0] status;
        logic       emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic bad;
        logic run_hit;
        logic row_last;
        logic col_last;
        logic write_last;
    } stat_t;

endpackage

>>> hdl/tfa_datapath.sv
// Datapath: grid registers, occupancy rows, scan counters and the result fields.
// Depends on tfa_pkg; driven by commands from tfa_ctrl.
module tfa_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [tfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tfa_pkg::DIM_W-1:0]         cfg_data,
    input  tfa_pkg::req_t                     req,
    input  tfa_pkg::cmd_t                     cmd,
    output tfa_pkg::stat_t                    stat,
    output tfa_pkg::rsp_t                     result
);

    logic [tfa_pkg::DIM_W-1:0]       cfg_w_reg, cfg_h_reg;
    logic [tfa_pkg::DIM_W-1:0]       gw, gh;
    logic                            op_reg;
    logic [tfa_pkg::DIM_W-1:0]       w_reg, h_reg;
    logic [4:0]                      px_reg, py_reg;
    logic [tfa_pkg::COL_W-1:0]       x_reg;
    logic [tfa_pkg::ROW_W-1:0]       y_reg;
    logic [tfa_pkg::DIM_W-1:0]       run_reg;
    logic [tfa_pkg::DIM_W-1:0]       cnt_reg;
    logic [4:0]                      fx_reg, fy_reg;
    logic [1:0]                      st_reg;
    logic [tfa_pkg::MAX_COLUMNS-1:0] occ_reg [tfa_pkg::MAX_ROWS];

    logic [tfa_pkg::MAX_COLUMNS-1:0] mask;
    logic [tfa_pkg::MAX_COLUMNS-1:0] row_data;
    logic                            row_free;
    logic [tfa_pkg::DIM_W-1:0]       run_inc;
    logic [tfa_pkg::DIM_W-1:0]       origin_y;
    logic [tfa_pkg::DIM_W:0]         x_end;
    logic                            size_zero, reserve_bad, release_bad;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= tfa_pkg::GRID_RESET;
            cfg_h_reg <= tfa_pkg::GRID_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                tfa_pkg::CFG_GRID_WIDTH:  cfg_w_reg <= cfg_data;
                tfa_pkg::CFG_GRID_HEIGHT: cfg_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign gw = (cfg_w_reg > tfa_pkg::DIM_W'(tfa_pkg::MAX_COLUMNS)) ?
                tfa_pkg::DIM_W'(tfa_pkg::MAX_COLUMNS) : cfg_w_reg;
    assign gh = (cfg_h_reg > tfa_pkg::DIM_W'(tfa_pkg::MAX_ROWS)) ?
                tfa_pkg::DIM_W'(tfa_pkg::MAX_ROWS) : cfg_h_reg;

    // column window of the current rectangle
    assign x_end = {1'b0, tfa_pkg::DIM_W'(x_reg)} + {1'b0, w_reg};
    always_comb
    begin
        for (int i = 0; i < tfa_pkg::MAX_COLUMNS; i++)
        begin
            mask[i] = ((tfa_pkg::DIM_W+1)'(i) >= {1'b0, tfa_pkg::DIM_W'(x_reg)}) &&
                      ((tfa_pkg::DIM_W+1)'(i) < x_end);
        end
    end

    assign row_data = occ_reg[y_reg];
    assign row_free = ((row_data & mask) == '0);
    assign run_inc  = run_reg + tfa_pkg::DIM_W'(1);
    assign origin_y = tfa_pkg::DIM_W'(y_reg) + tfa_pkg::DIM_W'(1) - h_reg;

    assign size_zero   = (w_reg == '0) || (h_reg == '0);
    assign reserve_bad = (w_reg > gw) || (h_reg > gh);
    assign release_bad = (({2'b00, px_reg} + {1'b0, w_reg}) > {1'b0, gw}) ||
                         (({2'b00, py_reg} + {1'b0, h_reg}) > {1'b0, gh});

    assign stat.op         = op_reg;
    assign stat.bad        = size_zero ||
                             ((op_reg == tfa_pkg::OP_RESERVE) ? reserve_bad : release_bad);
    assign stat.run_hit    = row_free && (run_inc == h_reg);
    assign stat.row_last   = (tfa_pkg::DIM_W'(y_reg) == gh - tfa_pkg::DIM_W'(1));
    assign stat.col_last   = (x_end == {1'b0, gw});
    assign stat.write_last = (cnt_reg + tfa_pkg::DIM_W'(1)) == h_reg;

    // item fields, counters and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            w_reg   <= req.region_width;
            h_reg   <= req.region_height;
            px_reg  <= req.place_x;
            py_reg  <= req.place_y;
            x_reg   <= '0;
            y_reg   <= '0;
            run_reg <= '0;
            cnt_reg <= '0;
            fx_reg  <= '0;
            fy_reg  <= '0;
        end
        else if (cmd.scan)
        begin
            run_reg <= row_free ? run_inc : '0;
            y_reg   <= y_reg + tfa_pkg::ROW_W'(1);
        end
        else if (cmd.next_col)
        begin
            x_reg   <= x_reg + tfa_pkg::COL_W'(1);
            y_reg   <= '0;
            run_reg <= '0;
        end
        else if (cmd.mark_found)
        begin
            fx_reg  <= 5'(x_reg);
            fy_reg  <= 5'(origin_y);
            y_reg   <= tfa_pkg::ROW_W'(origin_y);
            cnt_reg <= '0;
        end
        else if (cmd.release_start)
        begin
            x_reg   <= tfa_pkg::COL_W'(px_reg);
            y_reg   <= tfa_pkg::ROW_W'(py_reg);
            cnt_reg <= '0;
        end
        else if (cmd.write_step)
        begin
            y_reg   <= y_reg + tfa_pkg::ROW_W'(1);
            cnt_reg <= cnt_reg + tfa_pkg::DIM_W'(1);
        end

        if (cmd.set_status)
        begin
            st_reg <= cmd.status;
        end
    end

    // occupancy rows: read-modify-write of one row per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < tfa_pkg::MAX_ROWS; r++)
            begin
                occ_reg[r] <= '0;
            end
        end
        else if (cmd.write_step)
        begin
            occ_reg[y_reg] <= (op_reg == tfa_pkg::OP_RELEASE) ? (row_data & ~mask)
                                                               : (row_data | mask);
        end
    end

    assign result.status  = st_reg;
    assign result.found_x = fx_reg;
    assign result.found_y = fy_reg;

endmodule

>>> hdl/tfa_ctrl.sv
// Controller state machine: sequences check, scan, row writes and result hand-off.
// Depends on tfa_pkg; commands tfa_datapath.
module tfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    input  tfa_pkg::stat_t stat,
    output tfa_pkg::cmd_t  cmd
);

    tfa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tfa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tfa_pkg::S_CHECK;
                end
            end
            tfa_pkg::S_CHECK:
            begin
                if (stat.bad)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = tfa_pkg::RSP_BAD;
                    state_next     = tfa_pkg::S_DONE;
                end
                else if (stat.op == tfa_pkg::OP_RESERVE)
                begin
                    state_next = tfa_pkg::S_SCAN;
                end
                else
                begin
                    cmd.release_start = 1'b1;
                    state_next        = tfa_pkg::S_WRITE;
                end
            end
            tfa_pkg::S_SCAN:
            begin
                if (stat.run_hit)
                begin
                    cmd.mark_found = 1'b1;
                    state_next     = tfa_pkg::S_WRITE;
                end
                else if (stat.row_last)
                begin
                    if (stat.col_last)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = tfa_pkg::RSP_NO_ROOM;
                        state_next     = tfa_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.next_col = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            tfa_pkg::S_WRITE:
            begin
                cmd.write_step = 1'b1;
                if (stat.write_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = tfa_pkg::RSP_DONE;
                    state_next     = tfa_pkg::S_DONE;
                end
            end
            tfa_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tfa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/tile_region_first_fit_allocator.sv
// Top level of the tile region first-fit allocator: controller, datapath and result register.
// Depends on tfa_pkg, tfa_ctrl and tfa_datapath.
//
//   channel   signals                                    beat
//   request   in_valid / in_ready / in_data              tfa_pkg::req_t
//   result    out_valid / out_ready / out_data           tfa_pkg::rsp_t
//   config    cfg_write_en / cfg_index / cfg_data        6-bit grid size write
//
// One item at a time. A rejected item goes from the check straight to its result; a release
// writes region_height rows. A reserve scans one occupancy row per cycle for each candidate
// column, then writes region_height rows.
// The single-row read port of the occupancy rows sets this pace.
// Reset clears every tile to free at once and sets both grid registers to 32.
// The result register holds a finished beat while out_ready is low; a new request is taken
// meanwhile, and its own result waits in the controller until the register frees up.
module tile_region_first_fit_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tfa_pkg::req_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tfa_pkg::rsp_t                 out_data,
    input  logic                          cfg_write_en,
    input  logic [tfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfa_pkg::DIM_W-1:0]     cfg_data
);

    tfa_pkg::cmd_t  cmd;
    tfa_pkg::stat_t stat;
    tfa_pkg::rsp_t  result;
    tfa_pkg::rsp_t  out_data_reg;
    logic           out_valid_reg;
    logic           out_free;

    // the result register can take a beat when empty or draining this cycle
    assign out_free = !out_valid_reg || out_ready;

    tfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (in_data),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result)
    );

    // result register: load on emit, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hdl/tfa_checker.sv
// Port-level checks for the tile region first-fit allocator, and the bind that attaches them.
// Depends on tfa_pkg and tile_region_first_fit_allocator.
module tfa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input tfa_pkg::rsp_t out_data
);

    // only the three defined status codes ever leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == tfa_pkg::RSP_DONE ||
                       out_data.status == tfa_pkg::RSP_NO_ROOM ||
                       out_data.status == tfa_pkg::RSP_BAD))
        else $error("tfa: undefined status code");

    // failed requests carry a zero origin
    a_fail_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != tfa_pkg::RSP_DONE) |->
        (out_data.found_x == '0 && out_data.found_y == '0))
        else $error("tfa: nonzero origin on failed request");

    // one item at a time: the request side closes right after a beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("tfa: request taken while busy");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("tfa: result beat changed while stalled");

endmodule

bind tile_region_first_fit_allocator tfa_checker u_tfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
